>>> rtl/prk_pkg.sv
// Shared constants and types of the permutation rank engine.
package prk_pkg;

  // Fixed field widths of the channels.
  localparam int ValueW = 16;
  localparam int RankW  = 45;
  localparam int SizeW  = 5;

  // Size register value after reset.
  localparam int SizeReset = 16;

  // Default build parameters.
  localparam int MaxElemsDef  = 16;
  localparam int ValueBitsDef = 16;

  // Item modes.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModePerm = 1'b1;

  // Classified operation passed from the front part to the back part.
  typedef struct packed {
    logic is_load;  // Store the value into a slot.
    logic last;     // Final permutation value: the rank is emitted.
  } prk_op_t;

endpackage

>>> rtl/prk_if.sv
// Channel interfaces of the permutation rank engine: input, result and size write.
interface prk_in_if
  import prk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface prk_out_if
  import prk_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RankW-1:0] rank;
  logic             bad_value;

  modport source (output valid, output rank, output bad_value, input ready);
  modport sink   (input valid, input rank, input bad_value, output ready);
endinterface

interface prk_cfg_if
  import prk_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SizeW-1:0] size;

  modport source (output valid, output size, input ready);
  modport sink   (input valid, input size, output ready);
endinterface

>>> rtl/permutation_rank_engine_unit.sv
// Top level: permutation rank engine with size register, front part, queue and back part.
// Throughput: one beat per cycle in steady state while no final beat waits for an unread
// result; each beat takes one pass through the back part's slot match, unused-slot count
// and rank multiply-add. The result is valid in the cycle after the final permutation
// beat leaves the two-entry queue, which holds each beat after it is accepted.
// Reset: size reads 16, all counters, used slots, rank and error flag clear; the set
// store holds no defined data until loaded.
module permutation_rank_engine_unit
  import prk_pkg::*;
#(
  parameter int MAX_ELEMS  = MaxElemsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prk_cfg_if.sink   cfg_i,
  prk_in_if.sink    in_i,
  prk_out_if.source out_o
);

  localparam int CntW = $clog2(MAX_ELEMS + 1);
  localparam int StW  = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;
  localparam int QW   = $bits(prk_op_t) + 2 * CntW + StW;

  logic [SizeW-1:0] size_q, size_d;
  logic             cfg_we;

  logic             f_valid;
  logic             f_ready;
  prk_op_t          f_op;
  logic [CntW-1:0]  f_slot;
  logic [CntW-1:0]  f_factor;
  logic [StW-1:0]   f_value;

  logic             b_valid;
  logic             b_ready;
  logic [QW-1:0]    q_in;
  logic [QW-1:0]    q_out;
  prk_op_t          b_op;
  logic [CntW-1:0]  b_slot;
  logic [CntW-1:0]  b_factor;
  logic [StW-1:0]   b_value;

  // Size register: a write also clears the load and permutation state.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign size_d      = cfg_we ? cfg_i.size : size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(SizeReset);
    end else begin
      size_q <= size_d;
    end
  end

  prk_front #(
    .MAX_ELEMS  (MAX_ELEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we),
    .size_i     (size_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .mode_i     (in_i.mode),
    .value_i    (in_i.value),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op),
    .slot_o     (f_slot),
    .factor_o   (f_factor),
    .value_o    (f_value)
  );

  // Queue entries carry the classified beat as one word.
  assign q_in = {f_op, f_slot, f_factor, f_value};
  assign {b_op, b_slot, b_factor, b_value} = q_out;

  prk_fifo #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  prk_back #(
    .MAX_ELEMS  (MAX_ELEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we),
    .op_valid_i  (b_valid),
    .op_ready_o  (b_ready),
    .op_i        (b_op),
    .slot_i      (b_slot),
    .factor_i    (b_factor),
    .value_i     (b_value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .rank_o      (out_o.rank),
    .bad_value_o (out_o.bad_value)
  );

endmodule

>>> rtl/prk_front.sv
// Front part: accepts beats, tracks load and permutation positions, classifies each beat.
module prk_front
  import prk_pkg::*;
#(
  parameter int MAX_ELEMS  = MaxElemsDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int CntW = $clog2(MAX_ELEMS + 1),
  localparam int StW  = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic [SizeW-1:0]  size_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [ValueW-1:0] value_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output prk_op_t           op_o,
  output logic [CntW-1:0]   slot_o,
  output logic [CntW-1:0]   factor_o,
  output logic [StW-1:0]    value_o
);

  logic [CntW-1:0] elems;
  logic [CntW-1:0] load_cnt_q, load_cnt_d;
  logic [CntW-1:0] perm_cnt_q, perm_cnt_d;
  logic [CntW-1:0] load_slot;
  logic [CntW-1:0] perm_next;
  logic            is_last;
  logic            accept;

  // Effective element count: the size register clamped to 1..MAX_ELEMS.
  always_comb begin
    if (size_i == '0) begin
      elems = CntW'(1);
    end else if (32'(size_i) > MAX_ELEMS) begin
      elems = CntW'(MAX_ELEMS);
    end else begin
      elems = CntW'(size_i);
    end
  end

  // A load past the last slot starts again at slot one.
  assign load_slot = (load_cnt_q >= elems) ? CntW'(1) : load_cnt_q + CntW'(1);
  assign perm_next = perm_cnt_q + CntW'(1);
  assign is_last   = (perm_next >= elems);

  assign accept     = in_valid_i && op_ready_i;
  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;

  // Classified beat: loads carry their slot, permutation beats carry the search bound.
  always_comb begin
    op_o.is_load = (mode_i == ModeLoad);
    op_o.last    = (mode_i == ModePerm) && is_last;
    slot_o       = (mode_i == ModeLoad) ? load_slot : load_cnt_q;
    factor_o     = elems - perm_cnt_q;
    value_o      = value_i[StW-1:0];
  end

  // The position counter of the beat's mode advances on every accepted beat; a size write clears both.
  always_comb begin
    load_cnt_d = load_cnt_q;
    perm_cnt_d = perm_cnt_q;
    if (clear_i) begin
      load_cnt_d = '0;
      perm_cnt_d = '0;
    end else if (accept) begin
      if (mode_i == ModeLoad) begin
        load_cnt_d = load_slot;
      end else begin
        perm_cnt_d = is_last ? '0 : perm_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      perm_cnt_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      perm_cnt_q <= perm_cnt_d;
    end
  end

endmodule

>>> rtl/prk_fifo.sv
// Two-entry queue that decouples the front part from the back part.
module prk_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         push;
  logic         pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/prk_back.sv
// Back part: set store, slot match, unused-slot count and Horner rank update.
module prk_back
  import prk_pkg::*;
#(
  parameter int MAX_ELEMS  = MaxElemsDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int CntW = $clog2(MAX_ELEMS + 1),
  localparam int IdxW = $clog2(MAX_ELEMS),
  localparam int StW  = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             op_valid_i,
  output logic             op_ready_o,
  input  prk_op_t          op_i,
  input  logic [CntW-1:0]  slot_i,
  input  logic [CntW-1:0]  factor_i,
  input  logic [StW-1:0]   value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RankW-1:0] rank_o,
  output logic             bad_value_o
);

  logic [StW-1:0]       store_q [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] used_q, used_d;
  logic [RankW-1:0]     rank_q, rank_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  logic [RankW-1:0]     out_rank_q;
  logic                 out_bad_q;

  logic [MAX_ELEMS-1:0] match;
  logic [MAX_ELEMS-1:0] sel;
  logic [MAX_ELEMS-1:0] below;
  logic                 seen;
  logic                 bad;
  logic [CntW-1:0]      count;
  logic [RankW-1:0]     product;
  logic [RankW-1:0]     rank_nxt;
  logic                 pop;
  logic                 do_perm;
  logic [IdxW-1:0]      wr_idx;

  // A final beat waits until the result register is free.
  assign op_ready_o = !op_i.last || !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;
  assign do_perm    = pop && !op_i.is_load;
  assign wr_idx     = IdxW'(slot_i - CntW'(1));

  // Compare the value against every loaded slot up to the search bound.
  always_comb begin
    for (int s = 0; s < MAX_ELEMS; s++) begin
      match[s] = (store_q[s] == value_i) && (CntW'(s) < slot_i);
    end
  end

  // The highest matching slot wins.
  always_comb begin
    seen = 1'b0;
    sel  = '0;
    for (int s = MAX_ELEMS - 1; s >= 0; s--) begin
      sel[s] = match[s] && !seen;
      seen   = seen || match[s];
    end
  end

  // Absent or already used values are flagged and count zero.
  assign bad   = (sel == '0) || ((sel & used_q) != '0);
  assign below = sel - MAX_ELEMS'(1);

  always_comb begin
    count = '0;
    for (int s = 0; s < MAX_ELEMS; s++) begin
      count = count + CntW'(below[s] && !used_q[s] && !bad);
    end
  end

  // Horner step of the factorial-base rank, kept modulo the rank width.
  assign product  = rank_q * {{(RankW - CntW){1'b0}}, factor_i};
  assign rank_nxt = product + {{(RankW - CntW){1'b0}}, count};

  // Permutation state and result register update.
  always_comb begin
    used_d      = used_q;
    rank_d      = rank_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (clear_i) begin
      used_d = '0;
      rank_d = '0;
      err_d  = 1'b0;
    end else if (do_perm) begin
      if (op_i.last) begin
        used_d      = '0;
        rank_d      = '0;
        err_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        used_d = bad ? used_q : (used_q | sel);
        rank_d = rank_nxt;
        err_d  = err_q || bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rank_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      rank_q      <= rank_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload is captured with the final permutation beat.
  always_ff @(posedge clk_i) begin
    if (do_perm && op_i.last) begin
      out_rank_q <= rank_nxt;
      out_bad_q  <= err_q || bad;
    end
  end

  // Set store: one slot written per load beat.
  always_ff @(posedge clk_i) begin
    if (pop && op_i.is_load) begin
      store_q[wr_idx] <= value_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rank_o      = out_rank_q;
  assign bad_value_o = out_bad_q;

  // The slot selection of a waiting permutation beat never picks more than one slot.
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_i && !op_i.is_load) |-> $onehot0(sel))
    else $error("slot selection is not one-hot");

  // A final beat never overwrites a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_perm && op_i.last && out_valid_q && !out_ready_i))
    else $error("result register overrun");

  // A final beat leaves a pending result and a cleared permutation state.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_perm && op_i.last && !clear_i) |=>
      (out_valid_q && used_q == '0 && rank_q == '0 && !err_q))
    else $error("final beat did not emit and clear");

  // A successful match marks its slot as used.
  a_mark_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_perm && !op_i.last && !bad && !clear_i) |=> ((used_q & $past(sel)) != '0))
    else $error("matched slot not marked used");

endmodule
